// ===== rtl/recurrence_checksum_macros.svh =====
// ----------------------------------------------------------------------------
// Recurrence checksum assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RECURRENCE_CHECKSUM_MACROS_SVH
`define RECURRENCE_CHECKSUM_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define RCS_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define RCS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/recsum_pkg.sv =====
// ----------------------------------------------------------------------------
// Recurrence checksum package
// Types and fixed constants of the three-term recurrence checksum.
// ----------------------------------------------------------------------------
package recsum_pkg;

	typedef logic [15:0] term_t;
	typedef logic [7:0]  idx_t;

	// Coefficient multipliers applied to the byte index.
	localparam logic [7:0]  ALPHA_MUL    = 8'd17;
	localparam logic [7:0]  BETA_MUL     = 8'd31;
	// Offset added to the first byte of a message.
	localparam term_t       FIRST_OFFSET = 16'd7;
	// Folding modulus and a multiple of it that keeps the difference positive.
	localparam logic [16:0] FOLD_MOD     = 17'd65535;
	localparam logic [25:0] FOLD_BIAS    = 26'd16776960;

endpackage

// ===== rtl/recurrence_checksum.sv =====
// ----------------------------------------------------------------------------
// Recurrence checksum
// Three-term recurrence checksum over a byte message, one byte per word.
// ----------------------------------------------------------------------------
// A message enters one byte per word on the byte channel, with last_byte set
// on its final byte; that word produces exactly one word on the sum channel
// carrying the 16-bit checksum (0 to 65534), and other bytes produce nothing.
// The block takes one byte every cycle unless a final byte is stalled, and
// an accepted byte reaches its checksum through one input register, then the
// recurrence update that writes the term and checksum registers together.
// The recurrence itself (a 9x16 and an 8x16 multiply, a subtract and a fold
// modulo 65535) is the feedback path that sets the clock limit. While a
// checksum waits on a stalled sum channel, bytes that are not final still
// flow; only a second final byte waits behind it. A one-byte message gives
// the byte plus seven. A difference that goes negative is folded the way an
// unsigned 64-bit wrap would fold it, which is one more than the true
// remainder. The byte index wraps at 256, which leaves the coefficients
// unchanged.
// ----------------------------------------------------------------------------
`include "recurrence_checksum_macros.svh"

module recurrence_checksum
	import recsum_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        sum_valid,
	input  logic        sum_stall,
	output logic [15:0] checksum
);

	// Input stage.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	// Recurrence state.
	term_t       term_prev_q;
	term_t       term_cur_q;
	idx_t        byte_idx_q;
	logic        in_msg_q;

	// Output register.
	logic        sum_valid_q;
	term_t       checksum_q;

	logic        load_in;
	logic        fire_s1;

	logic [7:0]  alpha;
	logic [7:0]  beta;
	logic [8:0]  coef_a;
	logic [24:0] prod_pos;
	logic [23:0] prod_neg;
	logic        borrow;
	logic [25:0] diff;
	logic [16:0] fold;
	term_t       term_next;
	term_t       term_new;

	// The staged byte moves on unless it is a final byte and the checksum
	// register still holds a word that the sink has not taken.
	assign fire_s1    = valid_s1 && (!last_s1 || !sum_valid_q || !sum_stall);
	assign byte_stall = valid_s1 && !fire_s1;
	assign load_in    = byte_valid && !byte_stall;

	always_comb begin
		alpha    = 8'(byte_idx_q * ALPHA_MUL);
		beta     = 8'(byte_idx_q * BETA_MUL);
		coef_a   = {1'b0, data_s1} + {1'b0, alpha};
		prod_pos = {16'd0, coef_a} * {9'd0, term_cur_q};
		prod_neg = {16'd0, beta} * {8'd0, term_prev_q};
		// A 64-bit wrap of a negative difference adds one modulo 65535.
		borrow   = prod_pos < {1'b0, prod_neg};
		diff     = {1'b0, prod_pos} + FOLD_BIAS - {2'd0, prod_neg} + {25'd0, borrow};
		// 2^16 is one modulo 65535, so the upper bits fold onto the lower ones.
		fold     = {7'd0, diff[25:16]} + {1'b0, diff[15:0]};
		if (fold >= FOLD_MOD) begin
			term_next = 16'(fold - FOLD_MOD);
		end else begin
			term_next = fold[15:0];
		end
		// The first byte of a message restarts the recurrence.
		if (in_msg_q) begin
			term_new = term_next;
		end else begin
			term_new = {8'd0, data_s1} + FIRST_OFFSET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_prev_q <= 16'd1;
			term_cur_q  <= 16'd1;
			byte_idx_q  <= '0;
			in_msg_q    <= 1'b0;
		end else if (fire_s1) begin
			term_prev_q <= in_msg_q ? term_cur_q : 16'd1;
			term_cur_q  <= term_new;
			byte_idx_q  <= in_msg_q ? byte_idx_q + 8'd1 : 8'd1;
			in_msg_q    <= !last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			sum_valid_q <= 1'b1;
		end else if (!sum_stall) begin
			sum_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			checksum_q <= term_new;
		end
	end

	assign sum_valid = sum_valid_q;
	assign checksum  = checksum_q;

	// The fold never leaves the residue 65535 in the term registers.
	`RCS_ASSERT_SAME(a_term_range, 1'b1, term_cur_q != 16'hFFFF, "term out of range")
	// A delivered checksum is always reduced.
	`RCS_ASSERT_SAME(a_sum_range, sum_valid, checksum != 16'hFFFF, "checksum out of range")
	// Input backpressure only comes from a final byte behind a held checksum.
	`RCS_ASSERT_SAME(a_stall_cause, byte_stall,
		valid_s1 && last_s1 && sum_valid_q && sum_stall, "unexpected input stall")
	// A final byte closes the message.
	`RCS_ASSERT_NEXT(a_msg_close, fire_s1 && last_s1, !in_msg_q && sum_valid_q,
		"message not closed")

endmodule
